FILE: hdl/assert_macros.svh
// Assertion macros shared by the compass bearing RTL.
// Each macro assumes a clock named clock and a synchronous reset named reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("vtcb assertion failed");

// Next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("vtcb assertion failed");

`endif

FILE: hdl/vtcb_pkg.sv
// Package for the compass bearing pipeline: stage record, quadrant codes,
// fixed-point constants and the per-stage arctangent constant. No dependencies.
`timescale 1ns / 1ps

package vtcb_pkg;

   localparam int DATA_WIDTH    = 64;  // folded vector datapath
   localparam int ANGLE_WIDTH   = 32;  // angle accumulator, 2^-24 degree units
   localparam int ACC_FRAC      = 24;
   localparam int BEARING_WIDTH = 16;
   localparam int PRE_SHIFT_TOP = 60;  // left shift is PRE_SHIFT_TOP - component width

   localparam int DEG_QUARTER       = 90;
   localparam int DEG_HALF          = 180;
   localparam int DEG_THREE_QUARTER = 270;
   localparam int DEG_FULL          = 360;

   localparam int     ATAN_TABLE_LEN = 12;
   localparam longint RAD_TO_DEG_Q   = 64'sd961263669;

   localparam logic [ANGLE_WIDTH-1:0] ATAN_TABLE [ATAN_TABLE_LEN] = '{
      32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
      32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
      32'd3754917,   32'd1877466,   32'd938734,    32'd469367
   };

   // Quadrant the vector was folded from; selects the base angle
   typedef enum logic [1:0] {
      QUAD_UP    = 2'd0,
      QUAD_RIGHT = 2'd1,
      QUAD_DOWN  = 2'd2,
      QUAD_LEFT  = 2'd3
   } quadrant_type;

   // One pipeline slot, handed from cell to cell
   typedef struct packed {
      logic                          valid;
      quadrant_type                  quadrant;
      logic                          skip;     // on an axis: no rotation angle
      logic signed [DATA_WIDTH-1:0]  a;
      logic signed [DATA_WIDTH-1:0]  b;
      logic signed [ANGLE_WIDTH-1:0] z;
   } stage_type;

   // Rotation angle of one stage in 2^-24 degree units
   function automatic logic [ANGLE_WIDTH-1:0] stage_angle(input logic [5:0] index);
      longint rounded;
      if (index < 6'(ATAN_TABLE_LEN)) begin
         return ATAN_TABLE[index[3:0]];
      end
      rounded = (RAD_TO_DEG_Q + (longint'(1) << (index - 6'd1))) >>> index;
      return ANGLE_WIDTH'(rounded);
   endfunction

   // Base angle of a quadrant in whole degrees
   function automatic logic [8:0] quadrant_base(input quadrant_type quadrant);
      logic [8:0] base;
      unique case (quadrant)
         QUAD_UP:    base = 9'd0;
         QUAD_RIGHT: base = 9'(DEG_QUARTER);
         QUAD_DOWN:  base = 9'(DEG_HALF);
         QUAD_LEFT:  base = 9'(DEG_THREE_QUARTER);
         default:    base = 9'd0;
      endcase
      return base;
   endfunction

endpackage

FILE: hdl/vtcb_req_if.sv
// Request channel interface: valid/ready handshake with the vector components.
// Depends on nothing.
`timescale 1ns / 1ps

interface vtcb_req_if #(
   parameter int COMPONENT_WIDTH = 16
) ();
   logic                              valid;
   logic                              ready;
   logic signed [COMPONENT_WIDTH-1:0] delta_x;
   logic signed [COMPONENT_WIDTH-1:0] delta_y;

   modport source (output valid, output delta_x, output delta_y, input ready);
   modport sink   (input valid, input delta_x, input delta_y, output ready);
endinterface

FILE: hdl/vtcb_rsp_if.sv
// Response channel interface: valid/ready handshake with the bearing.
// Depends on nothing.
`timescale 1ns / 1ps

interface vtcb_rsp_if ();
   logic        valid;
   logic        ready;
   logic [15:0] bearing;

   modport source (output valid, output bearing, input ready);
   modport sink   (input valid, input bearing, output ready);
endinterface

FILE: hdl/vector_to_compass_bearing.sv
// Compass bearing of a signed vector by a chain of CORDIC vectoring cells.
// Stages from request to response: one fold stage, one cell per stage, and one
// rounding stage that is the output.
// Throughput: one request per cycle; the whole chain holds while a response waits.
// Reset (synchronous, active high) clears every valid bit; no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vector_to_compass_bearing #(
   parameter int COMPONENT_WIDTH     = 16,
   parameter int ANGLE_FRACTION_BITS = 7,
   parameter int CORDIC_STAGES       = 16
) (
   input  logic        clock,
   input  logic        reset,
   vtcb_req_if.sink    req_if,
   vtcb_rsp_if.source  rsp_if
);
   import vtcb_pkg::*;

   localparam int FULL_TURN = DEG_FULL << ANGLE_FRACTION_BITS;

   logic      advance;
   logic      up_axis_request;
   logic      bearing_in_range;
   stage_type chain [CORDIC_STAGES+1];

   // Move the chain whenever the output slot is free or being taken
   assign advance      = !rsp_if.valid || rsp_if.ready;
   assign req_if.ready = advance;

   vtcb_fold #(
      .COMPONENT_WIDTH (COMPONENT_WIDTH)
   ) u_fold (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .req_valid   (req_if.valid),
      .req_delta_x (req_if.delta_x),
      .req_delta_y (req_if.delta_y),
      .next_stage  (chain[0])
   );

   // Row of rotation cells
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      vtcb_cell #(
         .STAGE_INDEX (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .prev_stage (chain[i]),
         .next_stage (chain[i+1])
      );
   end

   vtcb_finish #(
      .ANGLE_FRACTION_BITS (ANGLE_FRACTION_BITS)
   ) u_finish (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .prev_stage  (chain[CORDIC_STAGES]),
      .rsp_valid   (rsp_if.valid),
      .rsp_bearing (rsp_if.bearing)
   );

   // Terms for the checks below
   assign up_axis_request = req_if.valid && req_if.ready && (req_if.delta_x == '0)
                            && (req_if.delta_y[COMPONENT_WIDTH-1] || (req_if.delta_y == '0));
   assign bearing_in_range = (FULL_TURN > 65535)
                             || (32'(rsp_if.bearing) < 32'(FULL_TURN));

   // An accepted request lands in the fold stage
   `ASSERT_NEXT(a_accept_fills, req_if.valid && req_if.ready, chain[0].valid)
   // A vector straight up or the zero vector folds to the up quadrant with no rotation
   `ASSERT_NEXT(a_up_axis, up_axis_request, chain[0].skip && (chain[0].quadrant == QUAD_UP))
   // A stalled last cell keeps its slot
   `ASSERT_NEXT(a_stall_holds, !advance && chain[CORDIC_STAGES].valid, $stable(chain[CORDIC_STAGES]))
   // Bearing stays below a full turn when a full turn fits the field
   `ASSERT_SAME(a_bearing_range, rsp_if.valid, bearing_in_range)

endmodule

FILE: hdl/vtcb_fold.sv
// Entry stage: folds a request vector into one quadrant and scales it up.
// Depends on vtcb_pkg.
`timescale 1ns / 1ps

module vtcb_fold #(
   parameter int COMPONENT_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic                              req_valid,
   input  logic signed [COMPONENT_WIDTH-1:0] req_delta_x,
   input  logic signed [COMPONENT_WIDTH-1:0] req_delta_y,
   output vtcb_pkg::stage_type               next_stage
);
   import vtcb_pkg::*;

   localparam int PRE_SHIFT = PRE_SHIFT_TOP - COMPONENT_WIDTH;

   stage_type                   stage_ff;
   stage_type                   stage_in;
   logic signed [COMPONENT_WIDTH:0] x_ext;
   logic signed [COMPONENT_WIDTH:0] y_ext;
   logic signed [COMPONENT_WIDTH:0] x_neg;
   logic signed [COMPONENT_WIDTH:0] y_neg;
   logic [COMPONENT_WIDTH:0]        a_mag;
   logic [COMPONENT_WIDTH:0]        b_mag;
   logic                            x_zero;
   logic                            y_zero;
   logic                            y_pos;

   // Pick the quadrant and the pair with a > 0, b >= 0 (both zero when x is zero)
   always_comb begin
      x_ext  = {req_delta_x[COMPONENT_WIDTH-1], req_delta_x};
      y_ext  = {req_delta_y[COMPONENT_WIDTH-1], req_delta_y};
      x_neg  = -x_ext;
      y_neg  = -y_ext;
      x_zero = (req_delta_x == '0);
      y_zero = (req_delta_y == '0);
      y_pos  = !req_delta_y[COMPONENT_WIDTH-1] && !y_zero;
      stage_in.valid = req_valid;
      stage_in.skip  = x_zero || y_zero;
      stage_in.z     = '0;
      if (x_zero) begin
         stage_in.quadrant = y_pos ? QUAD_DOWN : QUAD_UP;
         a_mag = '0;
         b_mag = '0;
      end else if (!req_delta_x[COMPONENT_WIDTH-1]) begin
         if (req_delta_y[COMPONENT_WIDTH-1]) begin
            stage_in.quadrant = QUAD_UP;
            a_mag = y_neg;
            b_mag = x_ext;
         end else begin
            stage_in.quadrant = QUAD_RIGHT;
            a_mag = x_ext;
            b_mag = y_ext;
         end
      end else begin
         if (y_pos) begin
            stage_in.quadrant = QUAD_DOWN;
            a_mag = y_ext;
            b_mag = x_neg;
         end else begin
            stage_in.quadrant = QUAD_LEFT;
            a_mag = x_neg;
            b_mag = y_neg;
         end
      end
      stage_in.a = DATA_WIDTH'(a_mag) << PRE_SHIFT;
      stage_in.b = DATA_WIDTH'(b_mag) << PRE_SHIFT;
   end

   // Capture on advance; reset clears only the valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign next_stage = stage_ff;

endmodule

FILE: hdl/vtcb_cell.sv
// One CORDIC vectoring cell: rotates the pair toward the axis by atan(2^-i).
// Depends on vtcb_pkg.
`timescale 1ns / 1ps

module vtcb_cell #(
   parameter int STAGE_INDEX = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  vtcb_pkg::stage_type prev_stage,
   output vtcb_pkg::stage_type next_stage
);
   import vtcb_pkg::*;

   localparam logic signed [ANGLE_WIDTH-1:0] STAGE_ANGLE =
      $signed(stage_angle(6'(STAGE_INDEX)));

   stage_type                     stage_ff;
   stage_type                     stage_in;
   logic signed [DATA_WIDTH-1:0]  a_cur;
   logic signed [DATA_WIDTH-1:0]  b_cur;
   logic signed [DATA_WIDTH-1:0]  da;
   logic signed [DATA_WIDTH-1:0]  db;
   logic signed [ANGLE_WIDTH-1:0] z_cur;

   // Rotate by the sign of b, both updates from the old pair
   always_comb begin
      a_cur    = prev_stage.a;
      b_cur    = prev_stage.b;
      z_cur    = prev_stage.z;
      da       = b_cur >>> STAGE_INDEX;
      db       = a_cur >>> STAGE_INDEX;
      stage_in = prev_stage;
      if (!b_cur[DATA_WIDTH-1]) begin
         stage_in.a = a_cur + da;
         stage_in.b = b_cur - db;
         stage_in.z = z_cur + STAGE_ANGLE;
      end else begin
         stage_in.a = a_cur - da;
         stage_in.b = b_cur + db;
         stage_in.z = z_cur - STAGE_ANGLE;
      end
   end

   // Hand the slot to the next cell on advance
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign next_stage = stage_ff;

endmodule

FILE: hdl/vtcb_finish.sv
// Exit stage: clamps and rounds the angle, adds the quadrant base, wraps 360.
// Depends on vtcb_pkg; drives the response register.
`timescale 1ns / 1ps

module vtcb_finish #(
   parameter int ANGLE_FRACTION_BITS = 7
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  vtcb_pkg::stage_type                 prev_stage,
   output logic                                rsp_valid,
   output logic [vtcb_pkg::BEARING_WIDTH-1:0]  rsp_bearing
);
   import vtcb_pkg::*;

   localparam int SUM_WIDTH = $clog2((DEG_FULL + 1) << ANGLE_FRACTION_BITS) + 1;
   localparam logic signed [ANGLE_WIDTH-1:0] QUARTER_Q =
      ANGLE_WIDTH'(DEG_QUARTER << ACC_FRAC);
   localparam logic [ANGLE_WIDTH:0] ROUND_HALF =
      (ANGLE_WIDTH+1)'(1) << (ACC_FRAC - 1 - ANGLE_FRACTION_BITS);
   localparam logic [SUM_WIDTH-1:0] FULL_SCALED =
      SUM_WIDTH'(DEG_FULL << ANGLE_FRACTION_BITS);

   logic                          rsp_valid_ff;
   logic [BEARING_WIDTH-1:0]      rsp_bearing_ff;
   logic [BEARING_WIDTH-1:0]      rsp_bearing_in;
   logic signed [ANGLE_WIDTH-1:0] z_clamped;
   logic [ANGLE_WIDTH:0]          z_rounded;
   logic [SUM_WIDTH-1:0]          base_scaled;
   logic [SUM_WIDTH-1:0]          sum;

   // Clamp to 0..a quarter turn, round half up, add the base and wrap
   always_comb begin
      if (prev_stage.skip || prev_stage.z[ANGLE_WIDTH-1]) begin
         z_clamped = '0;
      end else if (prev_stage.z > QUARTER_Q) begin
         z_clamped = QUARTER_Q;
      end else begin
         z_clamped = prev_stage.z;
      end
      z_rounded   = ({1'b0, z_clamped} + ROUND_HALF) >> (ACC_FRAC - ANGLE_FRACTION_BITS);
      base_scaled = SUM_WIDTH'(quadrant_base(prev_stage.quadrant)) << ANGLE_FRACTION_BITS;
      sum         = base_scaled + SUM_WIDTH'(z_rounded);
      if (sum >= FULL_SCALED) begin
         sum = sum - FULL_SCALED;
      end
      rsp_bearing_in = BEARING_WIDTH'(sum);
   end

   // Hold the response until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= prev_stage.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_bearing_ff <= rsp_bearing_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_bearing = rsp_bearing_ff;

endmodule
